### hdl/ir_volts_to_distance_loglog_core_assert.svh
// Assertion macros for the IR voltage to distance core.
`ifndef IR_VOLTS_TO_DISTANCE_LOGLOG_CORE_ASSERT_SVH
`define IR_VOLTS_TO_DISTANCE_LOGLOG_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define IVDLL_ASSERT_IMPLY(name, ck, rstn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define IVDLL_ASSERT_NEXT(name, ck, rstn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ivdll_pkg.sv
// Shared types, constants and table builders for the IR voltage to distance core.
package ivdll_pkg;

    localparam int ANCHOR_COUNT = 6;
    localparam int SEG_W        = $clog2(ANCHOR_COUNT - 1);
    localparam int PIPE_STAGES  = 11;

    localparam logic [14:0] DIST_MIN  = 15'd2560;
    localparam logic [14:0] DIST_MAX  = 15'd20480;
    localparam logic [17:0] DELTA_MAX = 18'd196607;

    // Anchors, voltage descending: Q2.14 volts, Q7.8 cm, Q1.12 slope magnitudes
    localparam logic [15:0] ANCHOR_V [ANCHOR_COUNT] =
        '{16'd49152, 16'd26214, 16'd19661, 16'd14746, 16'd9830, 16'd7373};
    localparam logic [14:0] ANCHOR_D [ANCHOR_COUNT] =
        '{15'd2560, 15'd5120, 15'd7680, 15'd10240, 15'd15360, 15'd20480};
    localparam logic [12:0] SEG_SLOPE [ANCHOR_COUNT - 1] =
        '{13'd4517, 13'd5773, 13'd4096, 13'd4096, 13'd4096};

    typedef enum logic [1:0] {
        ST_INTERP = 2'd0,
        ST_FAR    = 2'd1,
        ST_NEAR   = 2'd2
    } range_status_t;

    typedef enum logic [0:0] {
        REG_FAR_THRESHOLD  = 1'b0,
        REG_NEAR_THRESHOLD = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic en_a;
        logic en_b;
    } lerp_ctl_t;

    // Fraction bits of log2(y), y in Q1.30 within [1,2), by repeated squaring.
    function automatic logic [63:0] frac_log2(input logic [63:0] y_in, input int bits);
        logic [63:0] y;
        logic [63:0] r;
        y = y_in;
        r = '0;
        for (int b = 0; b < bits; b++)
        begin
            y = (y * y) >> 30;
            r = r << 1;
            if (y >= (64'd2 << 30))
            begin
                r[0] = 1'b1;
                y = y >> 1;
            end
        end
        return r;
    endfunction

    // Shift-subtract quotient, elaboration only.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // round(65536 * log2(1 + k/n))
    function automatic logic [16:0] log_entry(input int unsigned k, input int unsigned n);
        logic [63:0] y;
        if (k == n)
            return 17'd65536;
        y = udiv64((64'(n) + 64'(k)) << 30, 64'(n));
        return 17'((frac_log2(y, 40) + (64'd1 << 23)) >> 24);
    endfunction

    // Largest m with (2m-1)/65536 <= 2^(k/n)
    function automatic logic [16:0] exp_entry(input int unsigned k, input int unsigned n);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] y;
        lo = 64'd32768;
        hi = 64'd65536;
        while (lo < hi)
        begin
            mid = lo + ((hi - lo + 64'd1) >> 1);
            y   = ((64'd2 * mid) - 64'd1) << 14;
            if (frac_log2(y, 40) * 64'(n) <= (64'(k) << 40))
                lo = mid;
            else
                hi = mid - 64'd1;
        end
        return 17'(lo);
    endfunction

    // Signed Q.16 log2 of a Q2.14 value, same table interpolation as the datapath.
    function automatic logic signed [20:0] anchor_log2(input logic [15:0] v,
                                                       input int unsigned n);
        int unsigned p;
        logic [15:0] x;
        logic [63:0] f;
        logic [63:0] t;
        logic [63:0] idx;
        logic [63:0] r;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] fr;
        if (v == 16'd0)
            return -21'sd983040;
        p = 15;
        while (p > 0 && !v[p])
            p--;
        x   = v << (15 - p);
        f   = 64'(x) - 64'd32768;
        t   = f * 64'(n);
        idx = t >> 15;
        r   = t & 64'h7FFF;
        lo  = 64'(log_entry(32'(idx), n));
        hi  = 64'(log_entry(32'(idx) + 1, n));
        fr  = lo + (((hi - lo) * r + 64'd16384) >> 15);
        return 21'((longint'(p) - 14) * 65536 + longint'(fr));
    endfunction

endpackage

### hdl/ivdll_lerp.sv
// Two-stage table interpolator: base + round(diff * frac / 2^FRAC_W).
module ivdll_lerp #(
    parameter int FRAC_W = 15
) (
    input  logic                 clk,
    input  ivdll_pkg::lerp_ctl_t ctl,
    input  logic [16:0]          base,
    input  logic [16:0]          diff,
    input  logic [FRAC_W-1:0]    frac,
    output logic [16:0]          result
);

    localparam int PROD_W = 17 + FRAC_W;

    logic [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0] prod_reg;
    logic [16:0]       base_reg;
    logic [PROD_W:0]   rnd;
    logic [16:0]       result_next;
    logic [16:0]       result_reg;

    assign prod_next = PROD_W'(diff) * PROD_W'(frac);

    always_ff @(posedge clk)
    begin
        if (ctl.en_a)
        begin
            prod_reg <= prod_next;
            base_reg <= base;
        end
    end

    // round half up on the dropped fraction bits
    assign rnd         = {1'b0, prod_reg} + ((PROD_W + 1)'(1) << (FRAC_W - 1));
    assign result_next = base_reg + 17'(rnd >> FRAC_W);

    always_ff @(posedge clk)
    begin
        if (ctl.en_b)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

### hdl/ir_volts_to_distance_loglog_core.sv
// Top level: IR sensor voltage (Q2.14 V) to distance (Q7.8 cm), log-log interpolation.
//
// Input channel: sample_valid / sample_ready carry one voltage per transfer.
// Output channel: result_valid / result_ready carry distance and range_status.
// Configuration: cfg_we writes cfg_data into the threshold chosen by cfg_index
// (0 far, 1 near) at the clock edge; write only while the pipeline is empty.
// Pipeline: 11 register stages (classify/normalize, log table read, two
// interpolation stages, log difference, slope multiply, exp table read, two
// interpolation stages, anchor scale multiply, round/shift/clamp).
// Throughput: one item per cycle while the receiver keeps result_ready high.
// Stalls: each stage holds while the one after it is full and blocked, so
// a stalled receiver backs the pipeline up stage by stage; empty stages still
// fill, and sample_ready drops only once every stage holds an item.
// Reset: clears all stage valid bits and loads far = 6554 (0.40 V) and
// near = 45875 (2.80 V).
`include "ir_volts_to_distance_loglog_core_assert.svh"

module ir_volts_to_distance_loglog_core #(
    parameter int LOG_TABLE_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        sample_valid,
    output logic        sample_ready,
    input  logic [15:0] voltage,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [14:0] distance,
    output logic [1:0]  range_status
);

    localparam int NS = ivdll_pkg::PIPE_STAGES;
    localparam int NA = ivdll_pkg::ANCHOR_COUNT;
    localparam int SW = ivdll_pkg::SEG_W;
    localparam int LW = $clog2(LOG_TABLE_ENTRIES + 1);
    localparam logic [LW-1:0] N_L = LW'(LOG_TABLE_ENTRIES);

    // ---------------- constant tables ----------------
    logic [16:0]        log_tab    [LOG_TABLE_ENTRIES + 1];
    logic [16:0]        exp_tab    [LOG_TABLE_ENTRIES + 1];
    logic signed [20:0] anchor_log [NA];

    for (genvar k = 0; k <= LOG_TABLE_ENTRIES; k++)
    begin : g_tab
        localparam logic [16:0] LOG_V = ivdll_pkg::log_entry(k, LOG_TABLE_ENTRIES);
        localparam logic [16:0] EXP_V = ivdll_pkg::exp_entry(k, LOG_TABLE_ENTRIES);
        assign log_tab[k] = LOG_V;
        assign exp_tab[k] = EXP_V;
    end

    for (genvar i = 0; i < NA; i++)
    begin : g_alog
        localparam logic signed [20:0] AL_V =
            ivdll_pkg::anchor_log2(ivdll_pkg::ANCHOR_V[i], LOG_TABLE_ENTRIES);
        assign anchor_log[i] = AL_V;
    end

    // ---------------- configuration ----------------
    logic [15:0] far_thr_reg;
    logic [15:0] near_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            far_thr_reg  <= 16'd6554;
            near_thr_reg <= 16'd45875;
        end
        else if (cfg_we)
        begin
            unique case (ivdll_pkg::cfg_reg_t'(cfg_index))
                ivdll_pkg::REG_FAR_THRESHOLD:  far_thr_reg  <= cfg_data;
                ivdll_pkg::REG_NEAR_THRESHOLD: near_thr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic [NS:1]   vld_reg;
    logic [NS:1]   vld_next;
    logic [NS+1:1] adv;
    logic [NS:0]   vld_in;

    assign adv[NS+1] = result_ready;
    assign vld_in    = {vld_reg, sample_valid};

    for (genvar s = 1; s <= NS; s++)
    begin : g_ctl
        // a stage moves when it is empty or the next one takes its item
        assign adv[s]      = !vld_reg[s] || adv[s+1];
        assign vld_next[s] = adv[s] ? vld_in[s-1] : vld_reg[s];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign sample_ready = adv[1];
    assign result_valid = vld_reg[NS];

    // ---------------- stage 1: classify, segment, normalize ----------------
    logic                     seg_found;
    logic [SW-1:0]            seg_next;
    logic [3:0]               p_next;
    logic [15:0]              x_next;
    ivdll_pkg::range_status_t st_next;

    always_comb
    begin
        seg_found = 1'b0;
        seg_next  = '0;
        // descending scan so the first matching segment wins
        for (int i = NA - 2; i >= 0; i--)
        begin
            if (voltage <= ivdll_pkg::ANCHOR_V[i] && voltage >= ivdll_pkg::ANCHOR_V[i+1])
            begin
                seg_found = 1'b1;
                seg_next  = SW'(i);
            end
        end
    end

    always_comb
    begin
        p_next = '0;
        for (int b = 0; b < 16; b++)
        begin
            if (voltage[b])
                p_next = 4'(b);
        end
    end

    assign x_next = voltage << (4'd15 - p_next);

    always_comb
    begin
        if (voltage <= far_thr_reg)
            st_next = ivdll_pkg::ST_FAR;
        else if (voltage >= near_thr_reg)
            st_next = ivdll_pkg::ST_NEAR;
        else if (!seg_found)
            st_next = (voltage > ivdll_pkg::ANCHOR_V[0]) ? ivdll_pkg::ST_NEAR
                                                         : ivdll_pkg::ST_FAR;
        else
            st_next = ivdll_pkg::ST_INTERP;
    end

    logic [SW-1:0]            s1_seg_reg;
    logic [3:0]               s1_p_reg;
    logic [14:0]              s1_f_reg;
    ivdll_pkg::range_status_t s1_st_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_seg_reg <= seg_next;
            s1_p_reg   <= p_next;
            s1_f_reg   <= x_next[14:0];
            s1_st_reg  <= st_next;
        end
    end

    // ---------------- stage 2: log table read ----------------
    logic [15+LW-1:0] t1;
    logic [LW-1:0]    idx1;
    logic [LW-1:0]    idx1_p1;
    logic [16:0]      lbase_next;
    logic [16:0]      ldiff_next;

    assign t1         = (15 + LW)'(s1_f_reg) * (15 + LW)'(N_L);
    assign idx1       = t1[15+LW-1:15];
    assign idx1_p1    = idx1 + LW'(1);
    assign lbase_next = log_tab[idx1];
    assign ldiff_next = log_tab[idx1_p1] - log_tab[idx1];

    logic [SW-1:0]            s2_seg_reg;
    logic [3:0]               s2_p_reg;
    logic [16:0]              s2_base_reg;
    logic [16:0]              s2_diff_reg;
    logic [14:0]              s2_r_reg;
    ivdll_pkg::range_status_t s2_st_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s2_seg_reg  <= s1_seg_reg;
            s2_p_reg    <= s1_p_reg;
            s2_base_reg <= lbase_next;
            s2_diff_reg <= ldiff_next;
            s2_r_reg    <= t1[14:0];
            s2_st_reg   <= s1_st_reg;
        end
    end

    // ---------------- stages 3-4: log interpolation ----------------
    ivdll_pkg::lerp_ctl_t log_ctl;
    logic [16:0]          s4_frac;

    assign log_ctl.en_a = adv[3];
    assign log_ctl.en_b = adv[4];

    ivdll_lerp #(
        .FRAC_W (15)
    ) u_log_lerp (
        .clk    (clk),
        .ctl    (log_ctl),
        .base   (s2_base_reg),
        .diff   (s2_diff_reg),
        .frac   (s2_r_reg),
        .result (s4_frac)
    );

    logic [SW-1:0]            s3_seg_reg;
    logic [3:0]               s3_p_reg;
    ivdll_pkg::range_status_t s3_st_reg;
    logic [SW-1:0]            s4_seg_reg;
    logic [3:0]               s4_p_reg;
    ivdll_pkg::range_status_t s4_st_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s3_seg_reg <= s2_seg_reg;
            s3_p_reg   <= s2_p_reg;
            s3_st_reg  <= s2_st_reg;
        end
        if (adv[4])
        begin
            s4_seg_reg <= s3_seg_reg;
            s4_p_reg   <= s3_p_reg;
            s4_st_reg  <= s3_st_reg;
        end
    end

    // ---------------- stage 5: log distance from anchor ----------------
    logic signed [4:0]  p_s;
    logic signed [20:0] lg;
    logic [21:0]        dl_s;
    logic [20:0]        dl_next;

    assign p_s     = $signed({1'b0, s4_p_reg}) - 5'sd14;
    assign lg      = $signed({p_s, 16'h0000}) + $signed({4'b0000, s4_frac});
    assign dl_s    = {anchor_log[s4_seg_reg][20], anchor_log[s4_seg_reg]} - {lg[20], lg};
    assign dl_next = dl_s[21] ? '0 : dl_s[20:0];

    logic [SW-1:0]            s5_seg_reg;
    logic [20:0]              s5_dl_reg;
    ivdll_pkg::range_status_t s5_st_reg;

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s5_seg_reg <= s4_seg_reg;
            s5_dl_reg  <= dl_next;
            s5_st_reg  <= s4_st_reg;
        end
    end

    // ---------------- stage 6: slope multiply ----------------
    logic [33:0] sprod_next;

    assign sprod_next = 34'(ivdll_pkg::SEG_SLOPE[s5_seg_reg]) * 34'(s5_dl_reg);

    logic [SW-1:0]            s6_seg_reg;
    logic [33:0]              s6_prod_reg;
    ivdll_pkg::range_status_t s6_st_reg;

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            s6_seg_reg  <= s5_seg_reg;
            s6_prod_reg <= sprod_next;
            s6_st_reg   <= s5_st_reg;
        end
    end

    // ---------------- stage 7: delta, exp table read ----------------
    logic [34:0]      drnd;
    logic [22:0]      dfull;
    logic [17:0]      delta;
    logic [16+LW-1:0] t2;
    logic [LW-1:0]    idx2;
    logic [LW-1:0]    idx2_p1;
    logic [16:0]      ebase_next;
    logic [16:0]      ediff_next;

    assign drnd    = {1'b0, s6_prod_reg} + 35'd2048;
    assign dfull   = drnd[34:12];
    // integer part of delta is capped at 2 (shift of at most 4x)
    assign delta   = (dfull > 23'(ivdll_pkg::DELTA_MAX)) ? ivdll_pkg::DELTA_MAX
                                                         : dfull[17:0];
    assign t2         = (16 + LW)'(delta[15:0]) * (16 + LW)'(N_L);
    assign idx2       = t2[16+LW-1:16];
    assign idx2_p1    = idx2 + LW'(1);
    assign ebase_next = exp_tab[idx2];
    assign ediff_next = exp_tab[idx2_p1] - exp_tab[idx2];

    logic [SW-1:0]            s7_seg_reg;
    logic [1:0]               s7_ip_reg;
    logic [16:0]              s7_base_reg;
    logic [16:0]              s7_diff_reg;
    logic [15:0]              s7_r_reg;
    ivdll_pkg::range_status_t s7_st_reg;

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            s7_seg_reg  <= s6_seg_reg;
            s7_ip_reg   <= delta[17:16];
            s7_base_reg <= ebase_next;
            s7_diff_reg <= ediff_next;
            s7_r_reg    <= t2[15:0];
            s7_st_reg   <= s6_st_reg;
        end
    end

    // ---------------- stages 8-9: exp interpolation ----------------
    ivdll_pkg::lerp_ctl_t exp_ctl;
    logic [16:0]          s9_exp;

    assign exp_ctl.en_a = adv[8];
    assign exp_ctl.en_b = adv[9];

    ivdll_lerp #(
        .FRAC_W (16)
    ) u_exp_lerp (
        .clk    (clk),
        .ctl    (exp_ctl),
        .base   (s7_base_reg),
        .diff   (s7_diff_reg),
        .frac   (s7_r_reg),
        .result (s9_exp)
    );

    logic [SW-1:0]            s8_seg_reg;
    logic [1:0]               s8_ip_reg;
    ivdll_pkg::range_status_t s8_st_reg;
    logic [SW-1:0]            s9_seg_reg;
    logic [1:0]               s9_ip_reg;
    ivdll_pkg::range_status_t s9_st_reg;

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            s8_seg_reg <= s7_seg_reg;
            s8_ip_reg  <= s7_ip_reg;
            s8_st_reg  <= s7_st_reg;
        end
        if (adv[9])
        begin
            s9_seg_reg <= s8_seg_reg;
            s9_ip_reg  <= s8_ip_reg;
            s9_st_reg  <= s8_st_reg;
        end
    end

    // ---------------- stage 10: anchor distance scale ----------------
    logic [31:0] dprod_next;

    assign dprod_next = 32'(ivdll_pkg::ANCHOR_D[s9_seg_reg]) * 32'(s9_exp);

    logic [31:0]              s10_prod_reg;
    logic [1:0]               s10_ip_reg;
    ivdll_pkg::range_status_t s10_st_reg;

    always_ff @(posedge clk)
    begin
        if (adv[10])
        begin
            s10_prod_reg <= dprod_next;
            s10_ip_reg   <= s9_ip_reg;
            s10_st_reg   <= s9_st_reg;
        end
    end

    // ---------------- stage 11: round, shift, clamp ----------------
    logic [32:0]              srnd;
    logic [19:0]              scaled;
    logic [14:0]              dist_next;
    logic [14:0]              dist_reg;
    ivdll_pkg::range_status_t st_out_reg;

    assign srnd   = {1'b0, s10_prod_reg} + 33'd16384;
    assign scaled = 20'(srnd[32:15]) << s10_ip_reg;

    always_comb
    begin
        case (s10_st_reg)
            ivdll_pkg::ST_FAR:  dist_next = ivdll_pkg::DIST_MAX;
            ivdll_pkg::ST_NEAR: dist_next = ivdll_pkg::DIST_MIN;
            default:
            begin
                if (scaled < 20'(ivdll_pkg::DIST_MIN))
                    dist_next = ivdll_pkg::DIST_MIN;
                else if (scaled > 20'(ivdll_pkg::DIST_MAX))
                    dist_next = ivdll_pkg::DIST_MAX;
                else
                    dist_next = scaled[14:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[11])
        begin
            dist_reg   <= dist_next;
            st_out_reg <= s10_st_reg;
        end
    end

    assign distance     = dist_reg;
    assign range_status = st_out_reg;

    // ---------------- assertions ----------------
    `IVDLL_ASSERT_IMPLY(a_dist_range, clk, rst_n, result_valid, (distance >= ivdll_pkg::DIST_MIN && distance <= ivdll_pkg::DIST_MAX), "distance outside 10..80 cm")
    `IVDLL_ASSERT_IMPLY(a_near_dist, clk, rst_n, result_valid && range_status == ivdll_pkg::ST_NEAR, distance == ivdll_pkg::DIST_MIN, "near result is not 10 cm")
    `IVDLL_ASSERT_IMPLY(a_far_dist, clk, rst_n, result_valid && range_status == ivdll_pkg::ST_FAR, distance == ivdll_pkg::DIST_MAX, "far result is not 80 cm")
    `IVDLL_ASSERT_NEXT(a_enter, clk, rst_n, sample_valid && sample_ready, vld_reg[1], "accepted sample missing from first stage")

endmodule

### tb/testbench.sv
// Self-checking testbench for the IR voltage to distance core.
`timescale 1ns / 100ps

module testbench;

    localparam int LOG_PTS     = 64;
    localparam int NUM_ANCH    = 6;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = ivdll_pkg::PIPE_STAGES + 4;

    typedef struct {
        logic [14:0]              cm_q8;
        ivdll_pkg::range_status_t status;
    } range_reading_t;

    class distance_scoreboard;
        int unsigned    far_thr;
        int unsigned    near_thr;
        int unsigned    anchor_volts[NUM_ANCH];
        int unsigned    anchor_cm[NUM_ANCH];
        int unsigned    slope_q12[NUM_ANCH - 1];
        longint unsigned log_pts[LOG_PTS + 1];
        longint unsigned exp_pts[LOG_PTS + 1];
        longint         anchor_lg[NUM_ANCH];
        range_reading_t pending[$];
        int             errors;

        function new();
            anchor_volts = '{49152, 26214, 19661, 14746, 9830, 7373};
            anchor_cm    = '{2560, 5120, 7680, 10240, 15360, 20480};
            slope_q12    = '{4517, 5773, 4096, 4096, 4096};
            far_thr      = 6554;
            near_thr     = 45875;
            errors       = 0;
            build_curves();
        endfunction

        // log2 fraction bits of a Q1.30 mantissa in [1,2), by squaring
        function longint unsigned log2_bits(longint unsigned y_in, int nbits);
            longint unsigned y;
            longint unsigned acc;
            y   = y_in;
            acc = 0;
            for (int b = 0; b < nbits; b++)
            begin
                y   = (y * y) >> 30;
                acc = acc << 1;
                if (y >= (64'd2 << 30))
                begin
                    acc = acc | 64'd1;
                    y   = y >> 1;
                end
            end
            return acc;
        endfunction

        function void build_curves();
            longint unsigned lo;
            longint unsigned hi;
            longint unsigned mid;
            longint unsigned y;
            for (int k = 0; k <= LOG_PTS; k++)
            begin
                if (k == LOG_PTS)
                    log_pts[k] = 65536;
                else
                begin
                    y = ((64'(LOG_PTS) + 64'(k)) << 30) / 64'(LOG_PTS);
                    log_pts[k] = (log2_bits(y, 40) + (64'd1 << 23)) >> 24;
                end
                // largest m with (2m-1)/65536 <= 2^(k/N)
                lo = 32768;
                hi = 65536;
                while (lo < hi)
                begin
                    mid = lo + (hi - lo + 1) / 2;
                    y   = (2 * mid - 1) << 14;
                    if (log2_bits(y, 40) * 64'(LOG_PTS) <= (64'(k) << 40))
                        lo = mid;
                    else
                        hi = mid - 1;
                end
                exp_pts[k] = lo;
            end
            for (int i = 0; i < NUM_ANCH; i++)
                anchor_lg[i] = volts_log2(anchor_volts[i]);
        endfunction

        // signed Q.16 log2 of a Q2.14 voltage
        function longint volts_log2(int unsigned v);
            int              p;
            longint unsigned x;
            longint unsigned t;
            longint unsigned idx;
            longint unsigned r;
            longint unsigned fr;
            if (v == 0)
                return -15 * 65536;
            p = 15;
            while (p > 0 && ((v >> p) & 1) == 0)
                p--;
            x   = (64'(v) << (15 - p)) & 64'hFFFF;
            t   = (x - 32768) * 64'(LOG_PTS);
            idx = t >> 15;
            r   = t & 64'h7FFF;
            fr  = log_pts[idx] + (((log_pts[idx + 1] - log_pts[idx]) * r + 16384) >> 15);
            return (longint'(p) - 14) * 65536 + longint'(fr);
        endfunction

        // Q1.15 value of 2^(f/65536)
        function longint unsigned pow2_frac(longint unsigned f);
            longint unsigned t;
            longint unsigned idx;
            longint unsigned r;
            t   = (f & 64'hFFFF) * 64'(LOG_PTS);
            idx = t >> 16;
            r   = t & 64'hFFFF;
            return exp_pts[idx] + (((exp_pts[idx + 1] - exp_pts[idx]) * r + 32768) >> 16);
        endfunction

        function range_reading_t predict_distance(logic [15:0] v);
            range_reading_t  rd;
            int              seg;
            longint          dl;
            longint unsigned delta;
            longint unsigned scaled;
            int              ip;
            rd.status = ivdll_pkg::ST_INTERP;
            if (v <= far_thr)
            begin
                rd.cm_q8  = ivdll_pkg::DIST_MAX;
                rd.status = ivdll_pkg::ST_FAR;
            end
            else if (v >= near_thr)
            begin
                rd.cm_q8  = ivdll_pkg::DIST_MIN;
                rd.status = ivdll_pkg::ST_NEAR;
            end
            else
            begin
                // a voltage on an anchor takes the first segment that holds it
                seg = -1;
                for (int i = 0; i < NUM_ANCH - 1; i++)
                    if (seg < 0 && v <= anchor_volts[i] && v >= anchor_volts[i + 1])
                        seg = i;
                if (seg < 0)
                begin
                    if (v > anchor_volts[0])
                    begin
                        rd.cm_q8  = ivdll_pkg::DIST_MIN;
                        rd.status = ivdll_pkg::ST_NEAR;
                    end
                    else
                    begin
                        rd.cm_q8  = ivdll_pkg::DIST_MAX;
                        rd.status = ivdll_pkg::ST_FAR;
                    end
                end
                else
                begin
                    dl = anchor_lg[seg] - volts_log2(v);
                    if (dl < 0)
                        dl = 0;
                    delta = (64'(slope_q12[seg]) * longint'(dl) + 2048) >> 12;
                    if (delta > 196607)
                        delta = 196607;
                    ip     = int'(delta >> 16);
                    scaled = (64'(anchor_cm[seg]) * pow2_frac(delta) + 16384) >> 15;
                    scaled = scaled << ip;
                    if (scaled < ivdll_pkg::DIST_MIN)
                        scaled = ivdll_pkg::DIST_MIN;
                    if (scaled > ivdll_pkg::DIST_MAX)
                        scaled = ivdll_pkg::DIST_MAX;
                    rd.cm_q8 = scaled[14:0];
                end
            end
            return rd;
        endfunction

        function void note_voltage(logic [15:0] v);
            pending.push_back(predict_distance(v));
        endfunction

        function void check_result(logic [14:0] d, logic [1:0] s);
            range_reading_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: result with nothing pending: distance %0d status %0d",
                         $time, d, s);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (d !== want.cm_q8)
            begin
                $display("%0t: distance mismatch: expected %0d actual %0d",
                         $time, want.cm_q8, d);
                errors++;
            end
            if (s !== want.status)
            begin
                $display("%0t: range_status mismatch: expected %0d actual %0d",
                         $time, want.status, s);
                errors++;
            end
        endfunction
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_we       = 1'b0;
    logic        cfg_index    = 1'b0;
    logic [15:0] cfg_data     = 16'd0;
    logic        sample_valid = 1'b0;
    logic        sample_ready;
    logic [15:0] voltage      = 16'd0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [14:0] distance;
    logic [1:0]  range_status;

    distance_scoreboard board;
    int tx_idle_pct = 38;
    int rx_idle_pct = 38;
    int cycle_count = 0;

    ir_volts_to_distance_loglog_core #(
        .LOG_TABLE_ENTRIES(LOG_PTS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample_valid(sample_valid),
        .sample_ready(sample_ready),
        .voltage     (voltage),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .distance    (distance),
        .range_status(range_status)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge clk)
        result_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

    always @(posedge clk)
        if (result_valid === 1'b1 && result_ready === 1'b1)
            board.check_result(distance, range_status);

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_voltage(logic [15:0] v);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        voltage      <= v;
        do
            @(posedge clk);
        while (sample_ready !== 1'b1);
        board.note_voltage(v);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        sample_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic set_thresholds(logic [15:0] far_v, logic [15:0] near_v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= ivdll_pkg::REG_FAR_THRESHOLD;
        cfg_data  <= far_v;
        @(negedge clk);
        cfg_index <= ivdll_pkg::REG_NEAR_THRESHOLD;
        cfg_data  <= near_v;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.far_thr  = far_v;
        board.near_thr = near_v;
    endtask

    // Mostly in-range voltages, with anchor and threshold edges and raw noise
    function automatic logic [15:0] pick_voltage();
        int mode;
        int v;
        mode = $urandom_range(0, 99);
        if (mode < 60)
            v = $urandom_range(7373, 49152);
        else if (mode < 80)
            v = board.anchor_volts[$urandom_range(0, NUM_ANCH - 1)] + $urandom_range(0, 8) - 4;
        else if (mode < 90)
            v = (($urandom_range(0, 1) == 1) ? board.far_thr : board.near_thr)
                + $urandom_range(0, 4) - 2;
        else
            v = $urandom_range(0, 65535);
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    initial
    begin
        logic [15:0] at_reset[] = '{16'd0, 16'd65535, 16'd6554, 16'd6555, 16'd45874,
                                    16'd45875, 16'd49152, 16'd26214, 16'd19661,
                                    16'd14746, 16'd9830, 16'd7373, 16'd7374,
                                    16'd30000, 16'd17000, 16'd12000, 16'd8500, 16'd21845};
        logic [15:0] wide_open[] = '{16'd1, 16'd65534, 16'd49153, 16'd60000,
                                     16'd7372, 16'd100};
        int unsigned far_v;
        int unsigned near_v;
        int          n_items;

        board = new();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (at_reset[i])
            send_voltage(at_reset[i]);

        // thresholds out of the way: above top and below bottom anchor
        set_thresholds(16'd0, 16'd65535);
        foreach (wide_open[i])
            send_voltage(wide_open[i]);

        // both clamps hold, far wins
        set_thresholds(16'd65535, 16'd0);
        send_voltage(16'd30000);

        for (int ph = 0; ph < 8; ph++)
        begin
            n_items = 85;
            case (ph)
                0: begin far_v = 6554;  near_v = 45875; end
                1: begin far_v = 0;     near_v = 65535; end
                2: begin far_v = 7373;  near_v = 49152; end
                3: begin far_v = 65535; near_v = 0; n_items = 20; end
                5: begin far_v = $urandom_range(0, 65535); near_v = $urandom_range(0, 65535); end
                default:
                begin
                    far_v  = $urandom_range(0, 20000);
                    near_v = $urandom_range(30000, 65535);
                end
            endcase
            set_thresholds(far_v[15:0], near_v[15:0]);
            // one long stretch with both sides always willing
            tx_idle_pct = (ph == 2) ? 0 : 38;
            rx_idle_pct = (ph == 2) ? 0 : 38;
            repeat (n_items)
                send_voltage(pick_voltage());
        end

        wait_drained();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### ir_volts_to_distance_loglog_core.f
+incdir+hdl
hdl/ivdll_pkg.sv
hdl/ivdll_lerp.sv
hdl/ir_volts_to_distance_loglog_core.sv
tb/testbench.sv
